/* rtl/core/oast_pkg.sv */
package oast_pkg;

   localparam int Capacity = 64;
   localparam int MaxNameBytes = 32;
   localparam int IdxW = $clog2(Capacity);
   localparam int CntW = IdxW + 1;
   localparam int StepW = IdxW + 1;

   localparam logic [2:0] ST_FOUND = 3'd0;
   localparam logic [2:0] ST_UPDATED = 3'd1;
   localparam logic [2:0] ST_INSERTED = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL = 3'd4;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_REGISTER = 1'b1;

   typedef struct packed {
      logic        command;
      logic [31:0] key_hash;
      logic [5:0]  name_length;
      logic [63:0] name_word0;
      logic [63:0] name_word1;
      logic [63:0] name_word2;
      logic [63:0] name_word3;
      logic [31:0] native_handle;
      logic [31:0] intrinsic_handle;
      logic        batch_last;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  slot_index;
      logic [31:0] found_native;
      logic [31:0] found_intrinsic;
      logic        batch_done;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request, set first probe index
      logic rd;       // issue slot read at probe index
      logic advance;  // step probe index
      logic wr_upd;   // write handles
      logic wr_ins;   // write full entry
      logic finish;   // build response
      logic [2:0] status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_cmd_reg;
      logic empty;
      logic hit;
      logic full;
      logic last_try;
   } sts_type;

   function automatic logic [63:0] byte_mask(input logic [5:0] len, input int w);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++)
         if (32'(len) > 32'(w * 8 + b)) m[b*8 +: 8] = 8'hff;
      return m;
   endfunction

endpackage

/* rtl/core/oast_datapath.sv */
module oast_datapath (
   input  logic               clock,
   input  logic               reset,
   input  oast_pkg::req_type  req_in,
   input  oast_pkg::cmd_type  cmd,
   output oast_pkg::sts_type  sts,
   output oast_pkg::rsp_type  rsp_out
);
   localparam int IW = oast_pkg::IdxW;
   localparam int SW = oast_pkg::StepW;
   localparam int CW = oast_pkg::CntW;

   logic [oast_pkg::Capacity-1:0] valid_ff;
   logic [31:0]  mem_hash [oast_pkg::Capacity];
   logic [5:0]   mem_len  [oast_pkg::Capacity];
   logic [255:0] mem_name [oast_pkg::Capacity];
   logic [31:0]  mem_nat  [oast_pkg::Capacity];
   logic [31:0]  mem_int  [oast_pkg::Capacity];

   oast_pkg::req_type req_ff;
   logic [255:0] name_ff;
   logic [5:0]   len_ff;
   logic [IW-1:0] idx_ff, idx_in;
   logic [SW-1:0] step_ff;
   logic [CW-1:0] count_ff;
   logic [31:0]  rd_hash, rd_nat, rd_int;
   logic [5:0]   rd_len;
   logic [255:0] rd_name;
   logic         rd_valid;
   logic [IW-1:0] rd_idx;
   logic [5:0]   len_sat;
   logic [255:0] name_in;

   always_comb begin
      len_sat = (req_in.name_length > 6'(oast_pkg::MaxNameBytes)) ?
                6'(oast_pkg::MaxNameBytes) : req_in.name_length;
      name_in = {req_in.name_word3 & oast_pkg::byte_mask(len_sat, 3),
                 req_in.name_word2 & oast_pkg::byte_mask(len_sat, 2),
                 req_in.name_word1 & oast_pkg::byte_mask(len_sat, 1),
                 req_in.name_word0 & oast_pkg::byte_mask(len_sat, 0)};
      idx_in = cmd.load ? req_in.key_hash[IW-1:0] :
               IW'(idx_ff + step_ff[IW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req_in;
         name_ff <= name_in;
         len_ff  <= len_sat;
         step_ff <= SW'(1);
      end else if (cmd.advance) begin
         step_ff <= SW'(step_ff + SW'(1));
      end
      if (cmd.load || cmd.advance) idx_ff <= idx_in;
      if (cmd.rd) begin
         rd_hash <= mem_hash[idx_ff];
         rd_len  <= mem_len[idx_ff];
         rd_name <= mem_name[idx_ff];
         rd_nat  <= mem_nat[idx_ff];
         rd_int  <= mem_int[idx_ff];
         rd_valid <= valid_ff[idx_ff];
         rd_idx  <= idx_ff;
      end
      if (cmd.wr_upd || cmd.wr_ins) begin
         mem_nat[rd_idx] <= req_ff.native_handle;
         mem_int[rd_idx] <= req_ff.intrinsic_handle;
      end
      if (cmd.wr_ins) begin
         mem_hash[rd_idx] <= req_ff.key_hash;
         mem_len[rd_idx]  <= len_ff;
         mem_name[rd_idx] <= name_ff;
      end
      if (cmd.finish) begin
         rsp_out.status <= cmd.status;
         rsp_out.batch_done <= req_ff.batch_last;
         if (cmd.status == oast_pkg::ST_FOUND || cmd.status == oast_pkg::ST_UPDATED) begin
            rsp_out.slot_index <= 6'(rd_idx);
            rsp_out.found_native <= (cmd.status == oast_pkg::ST_FOUND) ? rd_nat :
                                    req_ff.native_handle;
            rsp_out.found_intrinsic <= (cmd.status == oast_pkg::ST_FOUND) ? rd_int :
                                       req_ff.intrinsic_handle;
         end else if (cmd.status == oast_pkg::ST_INSERTED) begin
            rsp_out.slot_index <= 6'(rd_idx);
            rsp_out.found_native <= req_ff.native_handle;
            rsp_out.found_intrinsic <= req_ff.intrinsic_handle;
         end else begin
            rsp_out.slot_index <= '0;
            rsp_out.found_native <= '0;
            rsp_out.found_intrinsic <= '0;
         end
      end
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (cmd.wr_ins) begin
         valid_ff[rd_idx] <= 1'b1;
         count_ff <= CW'(count_ff + CW'(1));
      end
   end

   always_comb begin
      sts.is_cmd_reg = (req_ff.command == oast_pkg::CMD_REGISTER);
      sts.empty = !rd_valid;
      sts.hit = rd_valid && rd_hash == req_ff.key_hash && rd_len == len_ff &&
                rd_name == name_ff;
      sts.full = ({count_ff, 2'b00} > (CW+2)'(oast_pkg::Capacity * 3));
      // step has reached capacity on the last probe
      sts.last_try = (step_ff == SW'(oast_pkg::Capacity));
   end
endmodule

/* rtl/core/oast_ctrl.sv */
module oast_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  oast_pkg::sts_type sts,
   output oast_pkg::cmd_type cmd
);
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_CHECK = 5'b00100,
      S_DONE  = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] status;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      status = oast_pkg::ST_NOT_FOUND;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            priority if (sts.hit) begin
               status = sts.is_cmd_reg ? oast_pkg::ST_UPDATED : oast_pkg::ST_FOUND;
               cmd.wr_upd = sts.is_cmd_reg;
               state_in = S_DONE;
            end else if (sts.empty) begin
               if (!sts.is_cmd_reg) status = oast_pkg::ST_NOT_FOUND;
               else if (sts.full) status = oast_pkg::ST_FULL;
               else begin
                  status = oast_pkg::ST_INSERTED;
                  cmd.wr_ins = 1'b1;
               end
               state_in = S_DONE;
            end else if (sts.last_try) begin
               status = sts.is_cmd_reg ? oast_pkg::ST_FULL : oast_pkg::ST_NOT_FOUND;
               state_in = S_DONE;
            end else begin
               cmd.advance = 1'b1;
               state_in = S_READ;
            end
            cmd.finish = (state_in == S_DONE);
            cmd.status = status;
         end
         S_DONE: state_in = S_OUT;
         S_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

/* rtl/core/open_addressing_symbol_table.sv */
// channel | dir | handshake          | payload
// req     | in  | req_valid/req_stall | req_data (req_type)
// rsp     | out | rsp_valid/rsp_stall | rsp_data (rsp_type)
// from one accept to the next, an item passes through these states, response beat included:
// the idle state, a read and a compare state per probe, a settle state, the response state.
// each probe is one registered read of the slot memory and a compare of hash, length, name.
// synchronous reset clears slot valid bits and the entry count at once.
// one item in flight; req_stall is high until the response beat is taken, and
// rsp_stall holds the response beat and so delays the next accept.
module open_addressing_symbol_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  oast_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output oast_pkg::rsp_type rsp_data
);
   oast_pkg::cmd_type cmd;
   oast_pkg::sts_type sts;

   oast_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd)
   );

   oast_datapath u_dp (
      .clock(clock), .reset(reset), .req_in(req_data), .cmd(cmd), .sts(sts),
      .rsp_out(rsp_data)
   );
endmodule

/* tb/open_addressing_symbol_table_test.sv */
module open_addressing_symbol_table_test;

   class symtab_scoreboard;
      bit          used[oast_pkg::Capacity];
      logic [31:0] key[oast_pkg::Capacity];
      logic [5:0]  len[oast_pkg::Capacity];
      logic [63:0] name[oast_pkg::Capacity][4];
      logic [31:0] native[oast_pkg::Capacity];
      logic [31:0] intrinsic[oast_pkg::Capacity];
      int          entries;
      oast_pkg::rsp_type pending[$];
      int          errors;

      function new();
         foreach (used[i]) used[i] = 0;
         entries = 0;
         errors = 0;
      endfunction

      static function logic [63:0] keep_bytes(int n, int w);
         logic [63:0] m;
         m = '0;
         for (int b = 0; b < 8; b++)
            if (n > w * 8 + b) m[b*8 +: 8] = 8'hff;
         return m;
      endfunction

      function void note_request(oast_pkg::req_type r);
         logic [63:0] nm[4];
         int          n, idx, stp;
         bit          hit, empty, same;
         oast_pkg::rsp_type e;
         n = (r.name_length > oast_pkg::MaxNameBytes) ? oast_pkg::MaxNameBytes
                                                      : int'(r.name_length);
         nm[0] = r.name_word0 & keep_bytes(n, 0);
         nm[1] = r.name_word1 & keep_bytes(n, 1);
         nm[2] = r.name_word2 & keep_bytes(n, 2);
         nm[3] = r.name_word3 & keep_bytes(n, 3);
         idx = int'(r.key_hash & 32'(oast_pkg::Capacity - 1));
         stp = 1;
         hit = 0;
         empty = 0;
         for (int t = 0; t < oast_pkg::Capacity; t++) begin
            if (!used[idx]) begin
               empty = 1;
               break;
            end
            same = key[idx] == r.key_hash && len[idx] == 6'(n);
            for (int w = 0; w < 4; w++) if (name[idx][w] != nm[w]) same = 0;
            if (same) begin
               hit = 1;
               break;
            end
            idx = (idx + stp) & (oast_pkg::Capacity - 1);
            stp++;
         end
         e = '0;
         e.batch_done = r.batch_last;
         if (r.command == oast_pkg::CMD_LOOKUP) begin
            e.status = hit ? oast_pkg::ST_FOUND : oast_pkg::ST_NOT_FOUND;
         end else if (hit) begin
            native[idx] = r.native_handle;
            intrinsic[idx] = r.intrinsic_handle;
            e.status = oast_pkg::ST_UPDATED;
         end else if (entries * 4 > oast_pkg::Capacity * 3 || !empty) begin
            e.status = oast_pkg::ST_FULL;
         end else begin
            used[idx] = 1;
            key[idx] = r.key_hash;
            len[idx] = 6'(n);
            for (int w = 0; w < 4; w++) name[idx][w] = nm[w];
            native[idx] = r.native_handle;
            intrinsic[idx] = r.intrinsic_handle;
            entries++;
            e.status = oast_pkg::ST_INSERTED;
            hit = 1;
         end
         if (hit) begin
            e.slot_index = 6'(idx);
            e.found_native = native[idx];
            e.found_intrinsic = intrinsic[idx];
         end
         pending.push_back(e);
      endfunction

      function void check_response(oast_pkg::rsp_type a);
         oast_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected response beat %h", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, a.status);
            errors++;
         end
         if (a.slot_index !== e.slot_index) begin
            $error("slot_index: expected %0d, got %0d", e.slot_index, a.slot_index);
            errors++;
         end
         if (a.found_native !== e.found_native) begin
            $error("found_native: expected %h, got %h", e.found_native, a.found_native);
            errors++;
         end
         if (a.found_intrinsic !== e.found_intrinsic) begin
            $error("found_intrinsic: expected %h, got %h", e.found_intrinsic,
                   a.found_intrinsic);
            errors++;
         end
         if (a.batch_done !== e.batch_done) begin
            $error("batch_done: expected %0d, got %0d", e.batch_done, a.batch_done);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   oast_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   oast_pkg::rsp_type rsp_data;

   symtab_scoreboard table_sb = new();
   oast_pkg::req_type known_names[$];
   int               burst_left = 0;
   int               cycle_count = 0;
   int               stall_mode = 0;

   open_addressing_symbol_table uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // receiver: stall pattern is redrawn at random among four modes
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) table_sb.check_response(rsp_data);
      cycle_count <= cycle_count + 1;
      if (cycle_count % 300 == 0) stall_mode <= int'($urandom_range(0, 3));
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 3);
         2: rsp_stall <= ($urandom_range(0, 9) < 8);
         default: rsp_stall <= cycle_count[2];
      endcase
   end

   task automatic send_beat(oast_pkg::req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = int'($urandom_range(1, 12));
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      table_sb.note_request(r);
   endtask

   function automatic oast_pkg::req_type make_name(logic cmd, logic [31:0] h, int n);
      oast_pkg::req_type r;
      r.command = cmd;
      r.key_hash = h;
      r.name_length = 6'(n);
      r.name_word0 = {$urandom, $urandom};
      r.name_word1 = {$urandom, $urandom};
      r.name_word2 = {$urandom, $urandom};
      r.name_word3 = {$urandom, $urandom};
      r.native_handle = $urandom;
      r.intrinsic_handle = $urandom;
      r.batch_last = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // same name, fresh handles, fresh garbage past the length
   function automatic oast_pkg::req_type reuse_name(oast_pkg::req_type p, logic cmd);
      oast_pkg::req_type r;
      int      n;
      r = make_name(cmd, p.key_hash, int'(p.name_length));
      n = (p.name_length > oast_pkg::MaxNameBytes) ? oast_pkg::MaxNameBytes
                                                   : int'(p.name_length);
      r.name_word0 = (p.name_word0 & symtab_scoreboard::keep_bytes(n, 0))
                   | (r.name_word0 & ~symtab_scoreboard::keep_bytes(n, 0));
      r.name_word1 = (p.name_word1 & symtab_scoreboard::keep_bytes(n, 1))
                   | (r.name_word1 & ~symtab_scoreboard::keep_bytes(n, 1));
      r.name_word2 = (p.name_word2 & symtab_scoreboard::keep_bytes(n, 2))
                   | (r.name_word2 & ~symtab_scoreboard::keep_bytes(n, 2));
      r.name_word3 = (p.name_word3 & symtab_scoreboard::keep_bytes(n, 3))
                   | (r.name_word3 & ~symtab_scoreboard::keep_bytes(n, 3));
      return r;
   endfunction

   function automatic logic [31:0] pick_hash();
      logic [31:0] h;
      h = $urandom;
      // crowd a few home slots so probe chains get long
      if ($urandom_range(0, 1)) h[5:0] = 6'($urandom_range(0, 3) * 21);
      return h;
   endfunction

   initial begin
      oast_pkg::req_type r, p;
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed: empty table, extremes, overlong length, collisions
      r = make_name(oast_pkg::CMD_LOOKUP, 32'h0, 0);
      send_beat(r);
      r = make_name(oast_pkg::CMD_REGISTER, 32'h0, 0);
      r.native_handle = '1;
      r.intrinsic_handle = '0;
      send_beat(r);
      send_beat(reuse_name(r, oast_pkg::CMD_LOOKUP));
      r = make_name(oast_pkg::CMD_REGISTER, 32'hffff_ffff, 32);
      send_beat(r);
      p = r;
      p.name_length = 6'd63;
      send_beat(reuse_name(p, oast_pkg::CMD_LOOKUP));
      p = make_name(oast_pkg::CMD_REGISTER, 32'h1234_5640, 40);
      send_beat(p);
      p.name_length = 6'd32;
      send_beat(reuse_name(p, oast_pkg::CMD_LOOKUP));
      send_beat(reuse_name(p, oast_pkg::CMD_REGISTER));
      for (int i = 0; i < 4; i++) begin
         r = make_name(oast_pkg::CMD_REGISTER, 32'(32'h0000_0040 * i), 1 + i * 7);
         send_beat(r);
         known_names.push_back(r);
         send_beat(reuse_name(r, oast_pkg::CMD_LOOKUP));
      end
      r = known_names[1];
      r.name_length = 6'(r.name_length + 6'd1);
      send_beat(reuse_name(r, oast_pkg::CMD_LOOKUP));
      r = known_names[2];
      r.name_word0 = ~r.name_word0;
      send_beat(reuse_name(r, oast_pkg::CMD_LOOKUP));
      r = known_names[3];
      r.key_hash = r.key_hash ^ 32'h8000_0000;
      send_beat(reuse_name(r, oast_pkg::CMD_LOOKUP));

      // random: mostly real names, some noise; the table fills up on the way
      for (int i = 0; i < 830; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               if (known_names.size() == 0)
                  r = make_name(oast_pkg::CMD_LOOKUP, pick_hash(), 5);
               else r = reuse_name(known_names[$urandom_range(0, known_names.size() - 1)],
                                   1'($urandom_range(0, 1)));
            end
            4, 5, 6, 7: begin
               r = make_name(oast_pkg::CMD_REGISTER, pick_hash(),
                             ($urandom_range(0, 7) == 0) ? int'($urandom_range(33, 63))
                                                         : int'($urandom_range(0, 32)));
               if (known_names.size() < 150) known_names.push_back(r);
            end
            default: r = make_name(1'($urandom_range(0, 1)), pick_hash(),
                                   int'($urandom_range(0, 63)));
         endcase
         send_beat(r);
      end
      req_valid <= 0;

      while (table_sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (table_sb.errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("TEST FAILED");
      $finish;
   end
endmodule

/* filelist.f */
rtl/core/oast_pkg.sv
rtl/core/oast_datapath.sv
rtl/core/oast_ctrl.sv
rtl/core/open_addressing_symbol_table.sv
tb/open_addressing_symbol_table_test.sv
